[hdl/ssmv_pkg.sv]
// Package for the sector sparse matrix-vector block: table sizes, action
// codes, sequencer states and the MAC control word. No dependencies.
`timescale 1ns / 1ps
package ssmv_pkg;

    localparam int MaxBasis   = 1024;
    localparam int MaxVector  = 4096;
    localparam int MaxInverse = 65536;
    localparam int MaxNonzero = 256;
    localparam int MaxBlock   = 256;
    localparam int RowDepth   = 17;

    localparam int InWidth  = 96;
    localparam int OutWidth = 80;

    // action codes carried in tuser
    typedef enum logic [2:0] {
        ACT_ROW_PTR = 3'd0,
        ACT_MATRIX  = 3'd1,
        ACT_VECTOR  = 3'd2,
        ACT_BASIS   = 3'd3,
        ACT_INVERSE = 3'd4,
        ACT_PARITY  = 3'd5,
        ACT_COMPUTE = 3'd6,
        ACT_NONE    = 3'd7
    } t_action;

    // configuration register indexes
    localparam logic [1:0] CFG_SIGN   = 2'd0;
    localparam logic [1:0] CFG_ONSITE = 2'd1;
    localparam logic [1:0] CFG_RIGHT  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP,
        S_P0,
        S_P1,
        S_P2,
        S_WALK,
        S_MX,
        S_INV,
        S_VEC,
        S_ADD,
        S_DONE
    } t_state;

    // control word for the shared multiply-accumulate unit
    typedef struct packed {
        logic clr;
        logic mul;
        logic add;
        logic neg;
    } t_mac_ctl;

endpackage

[hdl/sector_sparse_matvec.sv]
// Compute item: setup states S_MAP, S_P0, S_P1 and S_P2, then per operator row
// entry S_WALK, S_MX, S_INV, S_VEC and S_ADD (back to S_WALK after S_MX when the
// inverse address is out of range, after S_INV when the entry or its vector
// position is absent), then S_WALK and S_DONE close the row and hand off the
// result; loads are written when accepted. The rate is set by the row walk, one
// table gather chain per entry through the shared MAC. Not ready while a compute
// item is in progress, and a compute waits in S_DONE while the previous result
// is still held. Synchronous active-low reset clears control and config; the
// tables are undefined until written. Depends on ssmv_pkg and ssmv_mac.
`timescale 1ns / 1ps
module sector_sparse_matvec (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_addr,
    input  logic [8:0]                    i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // index[15:0] left_left[23:16] left_right[27:24] right_right[35:28]
    // right_left[39:36] column[43:40] number[75:44] position[89:76]
    // parity_bits[92:90], zero pad
    input  logic [ssmv_pkg::InWidth-1:0]  s_axis_tdata,
    // action[2:0]
    input  logic [2:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // basis[9:0] amplitude[73:10], zero pad
    output logic [ssmv_pkg::OutWidth-1:0] m_axis_tdata
);
    import ssmv_pkg::*;

    // input fields
    logic [15:0] w_idx;
    logic [7:0]  w_ll, w_rr;
    logic [3:0]  w_lr, w_rl, w_col;
    logic [31:0] w_num;
    logic [13:0] w_pos;
    logic [2:0]  w_par;
    t_action     w_act;
    logic        w_acc;

    assign w_idx = s_axis_tdata[15:0];
    assign w_ll  = s_axis_tdata[23:16];
    assign w_lr  = s_axis_tdata[27:24];
    assign w_rr  = s_axis_tdata[35:28];
    assign w_rl  = s_axis_tdata[39:36];
    assign w_col = s_axis_tdata[43:40];
    assign w_num = s_axis_tdata[75:44];
    assign w_pos = s_axis_tdata[89:76];
    assign w_par = s_axis_tdata[92:90];
    assign w_act = t_action'(s_axis_tuser);
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // configuration
    logic       r_sign;
    logic [4:0] r_os;
    logic [8:0] r_rs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sign <= 1'b0;
            r_os   <= 5'd2;
            r_rs   <= 9'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SIGN:   r_sign <= i_cfg_data[0];
                CFG_ONSITE: r_os   <= i_cfg_data[4:0];
                CFG_RIGHT:  r_rs   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // tables
    logic [12:0] rp_mem  [RowDepth];
    logic [3:0]  col_mem [MaxNonzero];
    logic [31:0] val_mem [MaxNonzero];
    logic [31:0] vec_mem [MaxVector];
    logic [23:0] bas_mem [MaxBasis];
    logic [13:0] inv_mem [MaxInverse];
    logic [2:0]  par_mem [MaxBlock];

    logic [4:0]  w_rp_ra;
    logic [7:0]  w_mat_ra, w_par_ra;
    logic [11:0] w_vec_ra;
    logic [9:0]  w_bas_ra;
    logic [15:0] w_inv_ra;

    logic [12:0] r_rp_q;
    logic [3:0]  r_col_q;
    logic [31:0] r_val_q, r_vec_q;
    logic [23:0] r_bas_q;
    logic [13:0] r_inv_q;
    logic [2:0]  r_par_q;

    logic w_ld;
    assign w_ld = w_acc;

    always_ff @(posedge i_clk) begin
        if (w_ld && w_act == ACT_ROW_PTR && w_idx < 16'(RowDepth)) begin
            rp_mem[w_idx[4:0]] <= w_pos[13] ? 13'd0 : w_pos[12:0];
        end
        r_rp_q <= rp_mem[w_rp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_ld && w_act == ACT_MATRIX && w_idx < 16'(MaxNonzero)) begin
            col_mem[w_idx[7:0]] <= w_col;
            val_mem[w_idx[7:0]] <= w_num;
        end
        r_col_q <= col_mem[w_mat_ra];
        r_val_q <= val_mem[w_mat_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_ld && w_act == ACT_VECTOR && w_idx < 16'(MaxVector)) begin
            vec_mem[w_idx[11:0]] <= w_num;
        end
        r_vec_q <= vec_mem[w_vec_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_ld && w_act == ACT_BASIS && w_idx < 16'(MaxBasis)) begin
            bas_mem[w_idx[9:0]] <= {w_rl, w_rr, w_lr, w_ll};
        end
        r_bas_q <= bas_mem[w_bas_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_ld && w_act == ACT_INVERSE) begin
            inv_mem[w_idx] <= w_pos[13] ? 14'd0 : {1'b1, w_pos[12:0]};
        end
        r_inv_q <= inv_mem[w_inv_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_ld && w_act == ACT_PARITY && w_idx < 16'(MaxBlock)) begin
            par_mem[w_idx[7:0]] <= w_par;
        end
        r_par_q <= par_mem[w_par_ra];
    end

    // sequencer registers
    t_state      r_state, n_state;
    logic [9:0]  r_basis, n_basis;
    logic [7:0]  r_ll, n_ll, r_rr, n_rr;
    logic [3:0]  r_lr, n_lr, r_rl, n_rl;
    logic [12:0] r_it, n_it;
    logic [8:0]  r_stop, n_stop;
    logic [26:0] r_t, n_t;
    logic        r_neg, n_neg;
    logic [31:0] r_val, n_val;
    logic        r_ovalid, n_ovalid;
    logic [63:0] r_oamp, n_oamp;
    logic [9:0]  r_obasis, n_obasis;

    logic [27:0] w_addr;
    logic        w_out_free;
    t_mac_ctl    w_mac;
    logic signed [63:0] w_amp;

    assign w_addr     = {1'b0, r_t} + 28'(r_col_q);
    assign w_out_free = !r_ovalid || m_axis_tready;

    ssmv_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac),
        .i_a     (r_vec_q),
        .i_b     (r_val),
        .o_acc   (w_amp)
    );

    // next state and datapath registers
    always_comb begin
        n_state  = r_state;
        n_basis  = r_basis;
        n_ll     = r_ll;
        n_lr     = r_lr;
        n_rr     = r_rr;
        n_rl     = r_rl;
        n_it     = r_it;
        n_stop   = r_stop;
        n_t      = r_t;
        n_neg    = r_neg;
        n_val    = r_val;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_oamp   = r_oamp;
        n_obasis = r_obasis;
        case (r_state)
            S_IDLE: begin
                if (w_acc && w_act == ACT_COMPUTE && w_idx < 16'(MaxBasis)) begin
                    n_basis = w_idx[9:0];
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                n_ll    = r_bas_q[7:0];
                n_lr    = r_bas_q[11:8];
                n_rr    = r_bas_q[19:12];
                n_rl    = r_bas_q[23:20];
                n_state = S_P0;
            end
            S_P0: begin
                n_it    = r_rp_q;
                n_neg   = r_sign && r_par_q[0];
                n_t     = 27'((r_ll * r_os) + 13'(r_lr));
                n_state = S_P1;
            end
            S_P1: begin
                n_stop  = (r_rp_q > 13'(MaxNonzero)) ? 9'(MaxNonzero) : r_rp_q[8:0];
                n_neg   = r_neg ^ (r_sign && r_par_q[1]);
                n_t     = 27'((r_t[12:0] * r_rs) + 22'(r_rr));
                n_state = S_P2;
            end
            S_P2: begin
                n_neg   = r_neg ^ (r_sign && r_par_q[2]);
                n_t     = 27'(r_t[21:0]) * 27'(r_os);
                n_state = S_WALK;
            end
            S_WALK: begin
                n_state = (r_it < 13'(r_stop)) ? S_MX : S_DONE;
            end
            S_MX: begin
                n_val = r_val_q;
                if (w_addr[27:16] != '0) begin
                    n_it    = r_it + 13'd1;
                    n_state = S_WALK;
                end else begin
                    n_state = S_INV;
                end
            end
            S_INV: begin
                if (!r_inv_q[13] || r_inv_q[12]) begin
                    n_it    = r_it + 13'd1;
                    n_state = S_WALK;
                end else begin
                    n_state = S_VEC;
                end
            end
            S_VEC: n_state = S_ADD;
            S_ADD: begin
                n_it    = r_it + 13'd1;
                n_state = S_WALK;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_oamp   = w_amp;
                    n_obasis = r_basis;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // read addresses, MAC control and handshake
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        w_bas_ra      = w_idx[9:0];
        w_rp_ra       = {1'b0, r_bas_q[23:20]};
        w_par_ra      = r_bas_q[7:0];
        w_mat_ra      = r_it[7:0];
        w_inv_ra      = w_addr[15:0];
        w_vec_ra      = r_inv_q[11:0];
        w_mac         = '{clr: 1'b0, mul: 1'b0, add: 1'b0, neg: r_neg};
        case (r_state)
            S_MAP: w_mac.clr = 1'b1;
            S_P0: begin
                w_rp_ra  = 5'(r_rl) + 5'd1;
                w_par_ra = {4'd0, r_lr};
            end
            S_P1:  w_par_ra = r_rr;
            S_VEC: w_mac.mul = 1'b1;
            S_ADD: w_mac.add = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_basis  <= n_basis;
        r_ll     <= n_ll;
        r_lr     <= n_lr;
        r_rr     <= n_rr;
        r_rl     <= n_rl;
        r_it     <= n_it;
        r_stop   <= n_stop;
        r_t      <= n_t;
        r_neg    <= n_neg;
        r_val    <= n_val;
        r_oamp   <= n_oamp;
        r_obasis <= n_obasis;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_oamp, r_obasis};

endmodule

[hdl/ssmv_mac.sv]
// Shared multiply-accumulate unit: registered 32x32 signed product, then a
// saturating 64-bit accumulate with optional negation. Uses ssmv_pkg.
`timescale 1ns / 1ps
module ssmv_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssmv_pkg::t_mac_ctl i_ctl,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_acc
);
    import ssmv_pkg::*;

    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [63:0] w_term;
    logic        [64:0] w_sum;

    // sign-adjusted product and wide sum
    assign w_term = i_ctl.neg ? -r_prod : r_prod;
    assign w_sum  = {r_acc[63], r_acc} + {w_term[63], w_term};

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= i_a * i_b;
        end
    end

    // accumulate with saturation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.add) begin
            if (w_sum[64] != w_sum[63]) begin
                r_acc <= w_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
                r_acc <= w_sum[63:0];
            end
        end
    end

    assign o_acc = r_acc;

endmodule
